@@ hdl/e2r_pkg.sv @@
`timescale 1ns / 1ps
// e2r_pkg: shared constants, arctangent table and Q2.30 multiply for the
// Euler angle to rotation matrix block. No dependencies.
package e2r_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int WORK_BITS        = 32;
    localparam int WORK_FRAC        = 30;
    localparam logic signed [WORK_BITS-1:0] GAIN_Q30 = 32'sd652032874;

    typedef logic signed [WORK_BITS-1:0] t_q30;

    function automatic logic [31:0] atan_bam(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2E;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            24:      v = 32'h00000028;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000002;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q2.30 product, rounded half up
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*WORK_BITS-1:0] p;
        p = a * b;
        p = p + (64'sd1 <<< (WORK_FRAC - 1));
        return p[WORK_FRAC +: WORK_BITS];
    endfunction

endpackage

@@ hdl/e2r_cordic.sv @@
`timescale 1ns / 1ps
// e2r_cordic: pipelined rotation-mode CORDIC, one register stage per step,
// plus input fold and output sign stages. Uses e2r_pkg.
module e2r_cordic
    import e2r_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_q30                  o_cos,
    output t_q30                  o_sin
);

    localparam int ZW = WORK_BITS + 1;

    logic [31:0] w_u;
    logic        w_flip;

    t_q30                 r_x [0:CORDIC_STEPS];
    t_q30                 r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    logic                 r_f [0:CORDIC_STEPS];
    t_q30                 r_cos;
    t_q30                 r_sin;

    assign w_u    = 32'(i_angle) << (32 - ANGLE_BITS);
    assign w_flip = w_u[31] ^ w_u[30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= ZW'(signed'({w_u[31] ^ w_flip, w_u[30:0]}));
            r_f[0] <= w_flip;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_f[i+1] <= r_f[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - signed'(ZW'(atan_bam(i)));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + signed'(ZW'(atan_bam(i)));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_f[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            r_sin <= r_f[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ hdl/e2r_matrix.sv @@
`timescale 1ns / 1ps
// e2r_matrix: three-stage product, sum and round/clamp pipeline that forms
// the nine rotation matrix entries. Uses e2r_pkg.
module e2r_matrix
    import e2r_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_q30                       i_cx,
    input  t_q30                       i_sx,
    input  t_q30                       i_cy,
    input  t_q30                       i_sy,
    input  t_q30                       i_cz,
    input  t_q30                       i_sz,
    output logic [9*(FRAC_BITS+2)-1:0] o_mat
);

    localparam int OW = FRAC_BITS + 2;
    localparam int SW = WORK_BITS + 2;
    localparam int SH = WORK_FRAC - FRAC_BITS;
    localparam logic signed [SW-1:0] RND = (SH > 0) ? (SW'(1) <<< (SH - 1)) : '0;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

    function automatic logic [OW-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = (v + RND) >>> SH;
        if (t > ONE)  t = ONE;
        if (t < -ONE) t = -ONE;
        return t[OW-1:0];
    endfunction

    // stage 1
    t_q30 r_czsy, r_szsy, r_czcy, r_szcy, r_cysx, r_cycx;
    t_q30 r_szcx, r_szsx, r_czcx, r_czsx, r1_sx, r1_cx, r1_sy;
    // stage 2
    t_q30 r_a01, r_a02, r_a11, r_a12;
    t_q30 r2_szcx, r2_szsx, r2_czcx, r2_czsx, r2_czcy, r2_szcy, r2_cysx, r2_cycx, r2_sy;
    // stage 3
    logic [9*OW-1:0] r_mat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czsy <= mul_q30(i_cz, i_sy);
            r_szsy <= mul_q30(i_sz, i_sy);
            r_czcy <= mul_q30(i_cz, i_cy);
            r_szcy <= mul_q30(i_sz, i_cy);
            r_cysx <= mul_q30(i_cy, i_sx);
            r_cycx <= mul_q30(i_cy, i_cx);
            r_szcx <= mul_q30(i_sz, i_cx);
            r_szsx <= mul_q30(i_sz, i_sx);
            r_czcx <= mul_q30(i_cz, i_cx);
            r_czsx <= mul_q30(i_cz, i_sx);
            r1_sx  <= i_sx;
            r1_cx  <= i_cx;
            r1_sy  <= i_sy;

            r_a01   <= mul_q30(r_czsy, r1_sx);
            r_a02   <= mul_q30(r_czsy, r1_cx);
            r_a11   <= mul_q30(r_szsy, r1_sx);
            r_a12   <= mul_q30(r_szsy, r1_cx);
            r2_szcx <= r_szcx;
            r2_szsx <= r_szsx;
            r2_czcx <= r_czcx;
            r2_czsx <= r_czsx;
            r2_czcy <= r_czcy;
            r2_szcy <= r_szcy;
            r2_cysx <= r_cysx;
            r2_cycx <= r_cycx;
            r2_sy   <= r1_sy;

            r_mat[0*OW +: OW] <= to_out(SW'(r2_czcy));
            r_mat[1*OW +: OW] <= to_out(SW'(r_a01) - SW'(r2_szcx));
            r_mat[2*OW +: OW] <= to_out(SW'(r_a02) + SW'(r2_szsx));
            r_mat[3*OW +: OW] <= to_out(SW'(r2_szcy));
            r_mat[4*OW +: OW] <= to_out(SW'(r_a11) + SW'(r2_czcx));
            r_mat[5*OW +: OW] <= to_out(SW'(r_a12) - SW'(r2_czsx));
            r_mat[6*OW +: OW] <= to_out(-SW'(r2_sy));
            r_mat[7*OW +: OW] <= to_out(SW'(r2_cysx));
            r_mat[8*OW +: OW] <= to_out(SW'(r2_cycx));
        end
    end

    assign o_mat = r_mat;

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// euler_to_rotation_matrix: roll/pitch/yaw to Z-Y-X rotation matrix.
// Pipeline: one fold stage, one stage per CORDIC step, one sign stage, three
// product/round stages. Throughput: one request per cycle; the whole pipeline
// holds when the output is stalled. Synchronous active-low reset clears the
// valid bits only.
// Uses e2r_pkg, e2r_cordic, e2r_matrix.
module euler_to_rotation_matrix
    import e2r_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int LAT   = CORDIC_STEPS + 5;
    localparam int OUT_W = 9 * (FRAC_BITS + 2);
    localparam int OUT_T = ((OUT_W + 7) / 8) * 8;

    logic           w_en;
    logic [LAT-1:0] r_vld;
    t_q30           w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    logic [OUT_W-1:0] w_mat;

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .i_clk(i_clk), .i_en(w_en), .i_angle(s_axis_tdata[0 +: ANGLE_BITS]),
        .o_cos(w_cx), .o_sin(w_sx)
    );

    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_angle(s_axis_tdata[ANGLE_BITS +: ANGLE_BITS]),
        .o_cos(w_cy), .o_sin(w_sy)
    );

    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_angle(s_axis_tdata[2*ANGLE_BITS +: ANGLE_BITS]),
        .o_cos(w_cz), .o_sin(w_sz)
    );

    e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_en(w_en),
        .i_cx(w_cx), .i_sx(w_sx), .i_cy(w_cy), .i_sy(w_sy), .i_cz(w_cz), .i_sz(w_sz),
        .o_mat(w_mat)
    );

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = OUT_T'(w_mat);

`ifndef SYNTH
    logic w_rng_ok;
    always_comb begin
        logic signed [FRAC_BITS+1:0] e;
        w_rng_ok = 1'b1;
        for (int k = 0; k < 9; k++) begin
            e = w_mat[k*(FRAC_BITS+2) +: FRAC_BITS+2];
            if (e > (FRAC_BITS+2)'(1 << FRAC_BITS) || e < -(FRAC_BITS+2)'(1 << FRAC_BITS))
                w_rng_ok = 1'b0;
        end
    end

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid not cleared by reset");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");
    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_rng_ok)
        else $error("matrix entry outside +-1.0");
`endif

endmodule
